// ===== hw/rtl/npcy_pkg.sv =====
package npcy_pkg;

   localparam int PAL_SIZE = 18;
   localparam int IDX_W    = 5;
   localparam int YW       = 24;   // luma, unsigned
   localparam int UW       = 24;   // chroma u, signed
   localparam int VW       = 25;   // chroma v, signed
   localparam int UPW      = 40;   // u product, signed
   localparam int VPW      = 41;   // v product, signed
   localparam int DW       = 51;   // squared distance

   localparam int KY_R = 19595;
   localparam int KY_G = 38470;
   localparam int KY_B = 7471;
   localparam logic signed [16:0] KU_S = 17'sd32309;
   localparam logic signed [16:0] KV_S = 17'sd57475;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } lane_en_type;

   // palette as {r, g, b}
   function automatic logic [23:0] pal_rgb(input int idx);
      logic [23:0] c;
      case (idx)
         0:       c = {8'd0,   8'd0,   8'd0};
         1:       c = {8'd255, 8'd255, 8'd255};
         2:       c = {8'd126, 8'd53,  8'd43};
         3:       c = {8'd110, 8'd183, 8'd193};
         4:       c = {8'd127, 8'd59,  8'd166};
         5:       c = {8'd92,  8'd160, 8'd53};
         6:       c = {8'd51,  8'd39,  8'd153};
         7:       c = {8'd203, 8'd215, 8'd101};
         8:       c = {8'd133, 8'd83,  8'd28};
         9:       c = {8'd80,  8'd60,  8'd0};
         10:      c = {8'd180, 8'd107, 8'd97};
         11:      c = {8'd74,  8'd74,  8'd74};
         12:      c = {8'd117, 8'd117, 8'd117};
         13:      c = {8'd163, 8'd231, 8'd124};
         14:      c = {8'd112, 8'd100, 8'd214};
         15:      c = {8'd163, 8'd163, 8'd163};
         16:      c = {8'd255, 8'd0,   8'd0};
         17:      c = {8'd0,   8'd255, 8'd0};
         default: c = 24'd0;
      endcase
      return c;
   endfunction

   function automatic longint pal_y(input int idx);
      logic [23:0] c;
      c = pal_rgb(idx);
      return longint'(KY_R) * longint'(c[23:16]) + longint'(KY_G) * longint'(c[15:8])
           + longint'(KY_B) * longint'(c[7:0]);
   endfunction

   function automatic longint pal_u(input int idx);
      logic [23:0] c;
      longint      bu;
      c  = pal_rgb(idx);
      bu = longint'(c[7:0]) * 65536 - pal_y(idx);
      return (bu * longint'(KU_S)) >>> 16;
   endfunction

   function automatic longint pal_v(input int idx);
      logic [23:0] c;
      longint      rv;
      c  = pal_rgb(idx);
      rv = longint'(c[23:16]) * 65536 - pal_y(idx);
      return (rv * longint'(KV_S)) >>> 16;
   endfunction

endpackage

// ===== hw/rtl/npcy_lane.sv =====
// One palette entry: distance from the pixel, three register stages.
module npcy_lane
   import npcy_pkg::*;
#(
   parameter int COLOR_IDX = 0
) (
   input  logic                  clock,
   input  lane_en_type           en,
   input  logic [YW-1:0]         yq,
   input  logic signed [UW-1:0]  uq,
   input  logic signed [VW-1:0]  vq,
   output logic [DW-1:0]         dist_sq
);

   localparam logic        [YW-1:0] PY = YW'(pal_y(COLOR_IDX));
   localparam logic signed [25:0]   PU = 26'(pal_u(COLOR_IDX));
   localparam logic signed [25:0]   PV = 26'(pal_v(COLOR_IDX));

   logic signed [25:0] dy, du, dv;
   logic [YW-1:0]      ady_in, ady_ff;
   logic [24:0]        adu_in, adu_ff, adv_in, adv_ff;
   logic [47:0]        sy_in, sy_ff;
   logic [49:0]        su_in, su_ff, sv_in, sv_ff;
   logic [DW-1:0]      dist_in, dist_ff;

   assign dy = $signed({2'b00, yq}) - $signed({2'b00, PY});
   assign du = 26'(uq) - PU;
   assign dv = 26'(vq) - PV;

   assign ady_in = dy[25] ? YW'(-dy) : YW'(dy);
   assign adu_in = du[25] ? 25'(-du) : 25'(du);
   assign adv_in = dv[25] ? 25'(-dv) : 25'(dv);

   assign sy_in = 48'(ady_ff) * 48'(ady_ff);
   assign su_in = 50'(adu_ff) * 50'(adu_ff);
   assign sv_in = 50'(adv_ff) * 50'(adv_ff);

   assign dist_in = DW'(sy_ff) + DW'(su_ff) + DW'(sv_ff);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         ady_ff <= ady_in;
         adu_ff <= adu_in;
         adv_ff <= adv_in;
      end
      if (en.s3) begin
         sy_ff <= sy_in;
         su_ff <= su_in;
         sv_ff <= sv_in;
      end
      if (en.s4) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_sq = dist_ff;

endmodule

// ===== hw/rtl/nearest_palette_color_yuv.sv =====
// Depth: 5 + clog2(NUM_COLORS) stages; rsp_tvalid is the last stage's valid bit.
// Throughput: one item per cycle; every stage holds one item and the pipeline
// is fully stallable, bubbles collapse under rsp back-pressure.
// The depth is set by the YUV multipliers, per-color squares and the
// registered minimum tree (one level per stage). Reset clears stage valid bits only.
module nearest_palette_color_yuv
   import npcy_pkg::*;
#(
   parameter int NUM_COLORS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // color_index[4:0], zero[7:5]
);

   localparam int LEVELS = $clog2(NUM_COLORS);
   localparam int LEAVES = 1 << LEVELS;
   localparam int NSTG   = 5 + LEVELS;

   logic [NSTG-1:0] en;
   logic [NSTG-1:0] v_in, v_ff;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign v_in = {v_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_tready = en[0];

   // stage 0: luma
   logic [7:0]    red, green, blue;
   logic [YW-1:0] yq_in, yq_ff, yq1_ff;
   logic [7:0]    red_ff, blue_ff;

   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = req_tdata[23:16];

   assign yq_in = YW'(red) * YW'(KY_R) + YW'(green) * YW'(KY_G) + YW'(blue) * YW'(KY_B);

   // stage 1: chroma products
   logic signed [24:0]    bu, rv;
   logic signed [UPW-1:0] uprod_in, uprod_ff;
   logic signed [VPW-1:0] vprod_in, vprod_ff;

   assign bu       = $signed({1'b0, blue_ff, 16'd0}) - $signed({1'b0, yq_ff});
   assign rv       = $signed({1'b0, red_ff, 16'd0}) - $signed({1'b0, yq_ff});
   assign uprod_in = UPW'(bu) * UPW'(KU_S);
   assign vprod_in = VPW'(rv) * VPW'(KV_S);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         yq_ff   <= yq_in;
         red_ff  <= red;
         blue_ff <= blue;
      end
      if (en[1]) begin
         yq1_ff   <= yq_ff;
         uprod_ff <= uprod_in;
         vprod_ff <= vprod_in;
      end
   end

   // stages 2..4: per-color distances (floor by 2^16 is the top slice)
   lane_en_type          lane_en;
   logic signed [UW-1:0] uq;
   logic signed [VW-1:0] vq;
   logic [DW-1:0]        lane_dist [NUM_COLORS];

   assign lane_en = '{s2: en[2], s3: en[3], s4: en[4]};
   assign uq      = uprod_ff[UPW-1:16];
   assign vq      = vprod_ff[VPW-1:16];

   for (genvar c = 0; c < NUM_COLORS; c++) begin : g_lane
      npcy_lane #(
         .COLOR_IDX (c)
      ) u_lane (
         .clock   (clock),
         .en      (lane_en),
         .yq      (yq1_ff),
         .uq      (uq),
         .vq      (vq),
         .dist_sq (lane_dist[c])
      );
   end

   // minimum tree, heap order: node 1 is the root; padded leaves never win
   logic [DW-1:0]    leaf_dist [LEAVES];
   logic [IDX_W-1:0] leaf_idx  [LEAVES];
   logic [DW-1:0]    node_dist_ff [1:LEAVES-1];
   logic [IDX_W-1:0] node_idx_ff  [1:LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < NUM_COLORS) begin : g_real
         assign leaf_dist[j] = lane_dist[j];
      end else begin : g_pad
         assign leaf_dist[j] = '1;
      end
      assign leaf_idx[j] = IDX_W'(j);
   end

   for (genvar i = 1; i < LEAVES; i++) begin : g_node
      localparam int DEPTH = $clog2(i + 1) - 1;
      localparam int STG   = 5 + LEVELS - 1 - DEPTH;
      logic [DW-1:0]    ld, rd;
      logic [IDX_W-1:0] li, ri;

      if (2 * i >= LEAVES) begin : g_from_leaf
         assign ld = leaf_dist[2*i-LEAVES];
         assign li = leaf_idx[2*i-LEAVES];
         assign rd = leaf_dist[2*i+1-LEAVES];
         assign ri = leaf_idx[2*i+1-LEAVES];
      end else begin : g_from_node
         assign ld = node_dist_ff[2*i];
         assign li = node_idx_ff[2*i];
         assign rd = node_dist_ff[2*i+1];
         assign ri = node_idx_ff[2*i+1];
      end

      // lower index wins a tie
      always_ff @(posedge clock) begin
         if (en[STG]) begin
            if (rd < ld) begin
               node_dist_ff[i] <= rd;
               node_idx_ff[i]  <= ri;
            end else begin
               node_dist_ff[i] <= ld;
               node_idx_ff[i]  <= li;
            end
         end
      end
   end

   assign rsp_tvalid = v_ff[NSTG-1];
   assign rsp_tdata  = {3'b000, node_idx_ff[1]};

endmodule

// ===== sim/tb_nearest_palette_color_yuv.sv =====
module tb_nearest_palette_color_yuv;
   import npcy_pkg::*;

   localparam int NCOL       = 18;
   localparam int HALF       = 4;
   localparam int DRAIN      = 40;
   localparam int CYCLE_CAP  = 200000;
   localparam int RAND_ITEMS = 850;

   // palette as {r, g, b}
   localparam logic [23:0] PALETTE [18] = '{
      {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255},
      {8'd126, 8'd53,  8'd43},  {8'd110, 8'd183, 8'd193},
      {8'd127, 8'd59,  8'd166}, {8'd92,  8'd160, 8'd53},
      {8'd51,  8'd39,  8'd153}, {8'd203, 8'd215, 8'd101},
      {8'd133, 8'd83,  8'd28},  {8'd80,  8'd60,  8'd0},
      {8'd180, 8'd107, 8'd97},  {8'd74,  8'd74,  8'd74},
      {8'd117, 8'd117, 8'd117}, {8'd163, 8'd231, 8'd124},
      {8'd112, 8'd100, 8'd214}, {8'd163, 8'd163, 8'd163},
      {8'd255, 8'd0,   8'd0},   {8'd0,   8'd255, 8'd0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // red[7:0], green[15:8], blue[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // color_index[4:0], zero[7:5]

   class palette_scoreboard;
      logic [IDX_W-1:0] expected_index[$];
      int               mismatches;
      int               accepted;

      function new();
         mismatches = 0;
         accepted   = 0;
      endfunction

      function void to_yuv(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           output longint y, output longint u, output longint v);
         longint lr, lg, lb;
         lr = r;
         lg = g;
         lb = b;
         y = 64'sd19595 * lr + 64'sd38470 * lg + 64'sd7471 * lb;
         // arithmetic shift of a signed longint floors
         u = ((lb * 65536 - y) * 64'sd32309) >>> 16;
         v = ((lr * 65536 - y) * 64'sd57475) >>> 16;
      endfunction

      function logic [IDX_W-1:0] nearest_index(input logic [23:0] pix);
         longint      py, pu, pv, cy, cu, cv, dy, du, dv, d, best_d;
         int          count, best;
         logic [23:0] c;
         count  = (NCOL > PAL_SIZE) ? PAL_SIZE : ((NCOL < 1) ? 1 : NCOL);
         best   = 0;
         best_d = 0;
         to_yuv(pix[7:0], pix[15:8], pix[23:16], py, pu, pv);
         for (int i = 0; i < count; i++) begin
            c = PALETTE[i];
            to_yuv(c[23:16], c[15:8], c[7:0], cy, cu, cv);
            dy = py - cy;
            du = pu - cu;
            dv = pv - cv;
            d  = dy * dy + du * du + dv * dv;
            // strict compare: ties keep the lower index
            if (i == 0 || d < best_d) begin
               best_d = d;
               best   = i;
            end
         end
         return best[IDX_W-1:0];
      endfunction

      function void note_pixel(input logic [23:0] pix);
         accepted++;
         expected_index.push_back(nearest_index(pix));
      endfunction

      function void check_result(input logic [7:0] data);
         logic [7:0] want;
         if (expected_index.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: got %0d", data);
            return;
         end
         want = {3'b000, expected_index.pop_front()};
         if (data !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("color_index mismatch: expected %0d, got %0d", want, data);
         end
      endfunction

      function int pending();
         return expected_index.size();
      endfunction
   endclass

   palette_scoreboard sb;
   int                cycles = 0;

   nearest_palette_color_yuv #(.NUM_COLORS(NCOL)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #HALF clock = ~clock;

   initial sb = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("nearest_palette_color_yuv regression: fail");
         $finish;
      end
   end

   function automatic logic [7:0] clamp8(input int x);
      if (x < 0)
         return 8'd0;
      if (x > 255)
         return 8'd255;
      return x[7:0];
   endfunction

   // holds valid until the item is taken; next call keeps valid high
   task automatic send_pixel(input logic [23:0] pix);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_input(input int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= 24'($urandom);
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [23:0] random_pixel();
      logic [23:0] a, b;
      int          mode;
      mode = $urandom_range(0, 9);
      a    = PALETTE[$urandom_range(0, PAL_SIZE - 1)];
      b    = PALETTE[$urandom_range(0, PAL_SIZE - 1)];
      if (mode < 3)
         return 24'($urandom);
      if (mode < 7)
         // near a palette color, decision boundaries close by; table is {r,g,b}
         return {clamp8(int'(a[7:0]) + $urandom_range(0, 12) - 6),
                 clamp8(int'(a[15:8]) + $urandom_range(0, 12) - 6),
                 clamp8(int'(a[23:16]) + $urandom_range(0, 12) - 6)};
      if (mode < 9)
         // midpoint of two palette colors, near-ties
         return {clamp8((int'(a[7:0]) + int'(b[7:0])) / 2 + $urandom_range(0, 2) - 1),
                 clamp8((int'(a[15:8]) + int'(b[15:8])) / 2 + $urandom_range(0, 2) - 1),
                 clamp8((int'(a[23:16]) + int'(b[23:16])) / 2 + $urandom_range(0, 2) - 1)};
      return {($urandom_range(0, 1) ? 8'd255 : 8'd0), 8'($urandom),
              ($urandom_range(0, 1) ? 8'd255 : 8'd0)};
   endfunction

   // receiver stall patterns, with two long hold-offs so the pipe backs up
   initial begin
      int  len, on_len, off_len;
      bit  hold_a, hold_b;
      hold_a = 1'b0;
      hold_b = 1'b0;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ((!hold_a && sb.accepted >= 250) || (!hold_b && sb.accepted >= 600)) begin
            if (!hold_a)
               hold_a = 1'b1;
            else
               hold_b = 1'b1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         len = $urandom_range(5, 60);
         case ($urandom_range(0, 2))
            0: begin
               repeat (len) begin
                  @(negedge clock);
                  rsp_tready <= 1'b1;
               end
            end
            1: begin
               repeat (len) begin
                  @(negedge clock);
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
            end
            default: begin
               on_len  = $urandom_range(1, 6);
               off_len = $urandom_range(1, 6);
               repeat (len / 4 + 1) begin
                  repeat (on_len) begin
                     @(negedge clock);
                     rsp_tready <= 1'b1;
                  end
                  repeat (off_len) begin
                     @(negedge clock);
                     rsp_tready <= 1'b0;
                  end
               end
            end
         endcase
      end
   end

   initial begin
      logic [23:0] directed[$];
      int          sent, burst;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 24'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every palette color exactly, then four cube corners and two near-black/white grays
      for (int i = 0; i < PAL_SIZE; i++)
         directed.push_back({PALETTE[i][7:0], PALETTE[i][15:8], PALETTE[i][23:16]});
      directed.push_back({8'd0,   8'd255, 8'd255});
      directed.push_back({8'd255, 8'd255, 8'd0});
      directed.push_back({8'd255, 8'd0,   8'd255});
      directed.push_back({8'd255, 8'd0,   8'd0});
      directed.push_back({8'd1,   8'd1,   8'd1});
      directed.push_back({8'd254, 8'd254, 8'd254});
      foreach (directed[i])
         send_pixel(directed[i]);
      idle_input($urandom_range(1, 8));

      sent = 0;
      while (sent < RAND_ITEMS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_pixel(random_pixel());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_input($urandom_range(1, 12));
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("nearest_palette_color_yuv regression: pass");
      else
         $display("nearest_palette_color_yuv regression: fail");
      $finish;
   end

endmodule
